[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared sizes, status codes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned MaxBlocks = 4096;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned WordCount = MaxBlocks / WordBits;

  localparam int unsigned BlkW  = $clog2(MaxBlocks);
  localparam int unsigned CntW  = BlkW + 1;
  localparam int unsigned AddrW = $clog2(WordCount);
  localparam int unsigned BitW  = $clog2(WordBits);
  localparam int unsigned NumWW = AddrW + 1;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StNoBlocks   = 2'd1,
    StDoubleFree = 2'd2,
    StOutOfRange = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SFreeChk,
    SDone
  } state_e;

endpackage

[rtl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a used-bit memory, one bit per block.
// Sequence: a free reads and checks its bitmap word, then its result loads
//   into the output register (out of range: no check); an allocate first scans,
//   one bitmap word per cycle. One item at a time, the next taken the cycle
//   after the result loads; a held result stalls it.
// Reset: the bitmap reads as all free through per-word valid bits, no
//   clearing pass; the block count register resets to 4096.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::CntW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [bba_pkg::BlkW-1:0]    block_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bba_pkg::BlkW-1:0]    granted_block_o,
  output logic [1:0]                  status_o
);

  localparam logic [bba_pkg::CntW-1:0] CapCount = bba_pkg::CntW'(bba_pkg::MaxBlocks);

  bba_pkg::state_e state_q, state_d;

  logic [bba_pkg::CntW-1:0] count_q;
  logic [bba_pkg::CntW-1:0] cnt;
  logic [bba_pkg::NumWW-1:0] num_words;
  logic [bba_pkg::NumWW-1:0] full_words;
  logic [bba_pkg::AddrW-1:0] last_word;

  // item and scan registers
  logic [bba_pkg::BlkW-1:0]   blk_q;
  logic [bba_pkg::AddrW-1:0]  chk_w_q, chk_w_d;
  logic [bba_pkg::BlkW-1:0]   res_blk_q, res_blk_d;
  bba_pkg::status_e           res_st_q, res_st_d;

  // bitmap memory
  bba_pkg::word_t             mem_q [bba_pkg::WordCount];
  logic [bba_pkg::WordCount-1:0] vld_q;
  bba_pkg::word_t             rdata_q;
  logic                       rvld_q;
  logic                       mem_re;
  logic [bba_pkg::AddrW-1:0]  raddr;
  logic                       mem_we;
  logic [bba_pkg::AddrW-1:0]  waddr;
  bba_pkg::word_t             wdata;

  bba_pkg::word_t             word;
  bba_pkg::word_t             lim_mask;
  bba_pkg::word_t             free_bits;
  bba_pkg::word_t             low_bit;
  logic [bba_pkg::BitW-1:0]   bit_idx;
  logic                       tgt_used;

  logic                       in_acc;
  logic                       out_load;
  logic                       out_valid_q;
  logic [bba_pkg::BlkW-1:0]   granted_q;
  bba_pkg::status_e           status_q;

  assign in_ready_o = (state_q == bba_pkg::SIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == bba_pkg::SDone) && (!out_valid_q || out_ready_i);

  // effective count and the word range it covers
  assign cnt        = (count_q > CapCount) ? CapCount : count_q;
  assign num_words  = bba_pkg::NumWW'((cnt + bba_pkg::CntW'(bba_pkg::WordBits - 1))
                      >> bba_pkg::BitW);
  assign full_words = bba_pkg::NumWW'(cnt >> bba_pkg::BitW);
  assign last_word  = bba_pkg::AddrW'(num_words - bba_pkg::NumWW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CapCount;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // never-written words read as all free
  assign word = rvld_q ? rdata_q : '0;

  always_comb begin
    if ({1'b0, chk_w_q} < full_words) begin
      lim_mask = '1;
    end else if ({1'b0, chk_w_q} == full_words) begin
      lim_mask = (bba_pkg::word_t'(1) << cnt[bba_pkg::BitW-1:0]) - bba_pkg::word_t'(1);
    end else begin
      lim_mask = '0;
    end
  end

  assign free_bits = ~word & lim_mask;
  assign low_bit   = free_bits & (~free_bits + bba_pkg::word_t'(1));
  assign tgt_used  = word[blk_q[bba_pkg::BitW-1:0]];

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < bba_pkg::WordBits; i++) begin
      if (low_bit[i]) begin
        bit_idx = bit_idx | bba_pkg::BitW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::SIdle: begin
        if (in_acc) begin
          if (mode_i) begin
            state_d = ({1'b0, block_number_i} >= cnt) ? bba_pkg::SDone : bba_pkg::SFreeChk;
          end else begin
            state_d = (num_words == '0) ? bba_pkg::SDone : bba_pkg::SScan;
          end
        end
      end
      bba_pkg::SScan: begin
        if (free_bits != '0 || chk_w_q == last_word) begin
          state_d = bba_pkg::SDone;
        end
      end
      bba_pkg::SFreeChk: state_d = bba_pkg::SDone;
      bba_pkg::SDone: begin
        if (out_load) begin
          state_d = bba_pkg::SIdle;
        end
      end
      default: state_d = bba_pkg::SIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_re    = 1'b0;
    raddr     = chk_w_q + bba_pkg::AddrW'(1);
    mem_we    = 1'b0;
    waddr     = chk_w_q;
    wdata     = word | low_bit;
    chk_w_d   = chk_w_q;
    res_blk_d = res_blk_q;
    res_st_d  = res_st_q;
    unique case (state_q)
      bba_pkg::SIdle: begin
        res_blk_d = '0;
        chk_w_d   = '0;
        if (in_acc) begin
          if (mode_i) begin
            raddr    = block_number_i[bba_pkg::BlkW-1:bba_pkg::BitW];
            mem_re   = 1'b1;
            res_st_d = ({1'b0, block_number_i} >= cnt) ? bba_pkg::StOutOfRange
                                                       : bba_pkg::StOk;
          end else begin
            raddr    = '0;
            mem_re   = 1'b1;
            res_st_d = (num_words == '0) ? bba_pkg::StNoBlocks : bba_pkg::StOk;
          end
        end
      end
      bba_pkg::SScan: begin
        if (free_bits != '0) begin
          mem_we    = 1'b1;
          res_blk_d = {chk_w_q, bit_idx};
          res_st_d  = bba_pkg::StOk;
        end else if (chk_w_q == last_word) begin
          res_st_d  = bba_pkg::StNoBlocks;
        end else begin
          // read ahead the next word
          mem_re  = 1'b1;
          chk_w_d = chk_w_q + bba_pkg::AddrW'(1);
        end
      end
      bba_pkg::SFreeChk: begin
        waddr = blk_q[bba_pkg::BlkW-1:bba_pkg::BitW];
        wdata = word & ~(bba_pkg::word_t'(1) << blk_q[bba_pkg::BitW-1:0]);
        if (tgt_used) begin
          mem_we   = 1'b1;
          res_st_d = bba_pkg::StOk;
        end else begin
          res_st_d = bba_pkg::StDoubleFree;
        end
      end
      bba_pkg::SDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::SIdle;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (mem_re) begin
        rvld_q <= vld_q[raddr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q <= block_number_i;
    end
    chk_w_q   <= chk_w_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      granted_q <= res_blk_q;
      status_q  <= res_st_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = granted_q;
  assign status_o        = status_q;

endmodule

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Port-level properties of the allocator, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [bba_pkg::BlkW-1:0] granted_block_o,
  input logic [1:0]               status_o
);

  // a result waiting for its taker holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_block_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // failed results carry no block number
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == 2'(bba_pkg::StNoBlocks)
      || status_o == 2'(bba_pkg::StDoubleFree)
      || status_o == 2'(bba_pkg::StOutOfRange)) |-> granted_block_o == '0)
    else $error("nonzero block on a failed result");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken twice in a row");

  // a new result appears only as the block goes back to idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result without return to idle");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .granted_block_o(granted_block_o),
  .status_o       (status_o)
);
